// File: rtl/core/sample_window_average_top_defines.svh
// Assertion macros used by the top-level RTL file of the sample window average block.
// Each check is sampled on the rising edge of clk and is disabled while arst_n is low.
`ifndef SAMPLE_WINDOW_AVERAGE_TOP_DEFINES_SVH
`define SAMPLE_WINDOW_AVERAGE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge.
`define SWA_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be true at a rising clock edge.
`define SWA_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define SWA_ASSERT_CLK(lbl, prop, msg)
`define SWA_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: rtl/core/swa_pkg.sv
package swa_pkg;

	// Store geometry and sample width.
	localparam int MAX_WINDOW  = 16;
	localparam int SAMPLE_BITS = 16;

	// Fixed field widths.
	localparam int FRAC_BITS = 4;
	localparam int WIN_W     = 5;
	localparam int AVG_W     = 20;

	// Derived widths.
	localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int EW_W   = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
	localparam int NUM_W  = SUM_W + FRAC_BITS;
	localparam int DCNT_W = $clog2(NUM_W + 1);
	localparam int REM_W  = EW_W;

	// Configuration port.
	localparam int  APB_ADDR_W  = 3;
	localparam int  APB_DATA_W  = 32;
	localparam logic ADDR_WINDOW = 1'b0;
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10);

	// Operations of the shared add/subtract unit.
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	// Request to the shared unit.
	typedef struct packed {
		alu_op_t           op;
		logic [SUM_W-1:0]  a;
		logic [SUM_W-1:0]  b;
	} alu_req_t;

endpackage

// File: rtl/core/swa_smp_if.sv
interface swa_smp_if;
	import swa_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   clear;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output clear, output sample, input ready);
	modport sink (input valid, input clear, input sample, output ready);
endinterface

// File: rtl/core/swa_res_if.sv
interface swa_res_if;
	import swa_pkg::*;

	logic             valid;
	logic             ready;
	logic [AVG_W-1:0] average;
	logic             valid_res;

	modport source (output valid, output average, output valid_res, input ready);
	modport sink (input valid, input average, input valid_res, output ready);
endinterface

// File: rtl/core/swa_alu.sv
module swa_alu (
	input  swa_pkg::alu_req_t         req,
	output logic [swa_pkg::SUM_W:0]   y
);
	import swa_pkg::*;

	// One adder serves both the window sum and the divider's trial subtraction.
	// The top bit is the carry on add and the borrow on subtract.
	always_comb begin
		case (req.op)
			ALU_ADD: y = {1'b0, req.a} + {1'b0, req.b};
			ALU_SUB: y = {1'b0, req.a} - {1'b0, req.b};
			default: y = '0;
		endcase
	end
endmodule

// File: rtl/core/sample_window_average_top.sv
// A sample transaction walks the effective window over the store (an empty slot ends the
// walk and skips the divide), then runs the 25-step restoring divide; a clear skips both.
// No new item is taken until the result of the last is handed over. Walk and divide share
// a single adder, one slot or one quotient bit per cycle.
// Reset (arst_n low, asynchronous): store empty, write position 0, window size 10, no result.
`include "sample_window_average_top_defines.svh"

module sample_window_average_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [swa_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [swa_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [swa_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	swa_smp_if.sink                          smp,
	swa_res_if.source                        res
);
	import swa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                 state_q;
	logic [WIN_W-1:0]       win_reg_q;
	logic [EW_W-1:0]        win_eff;
	logic [IDX_W-1:0]       pos_q;
	logic [EW_W-1:0]        pos_inc;
	logic [EW_W-1:0]        idx_q;
	logic [MAX_WINDOW-1:0]  used_q;
	logic [SAMPLE_BITS-1:0] store_q [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] entry;
	logic [SUM_W-1:0]       sum_q;
	logic [REM_W-1:0]       rem_q;
	logic [REM_W:0]         rem_sh;
	logic [NUM_W-1:0]       num_q;
	logic [DCNT_W-1:0]      dcnt_q;
	logic                   ok_q;
	logic                   res_valid_q;
	logic [AVG_W-1:0]       res_avg_q;
	logic                   res_ok_q;
	logic                   smp_take;
	logic                   cfg_wr;
	alu_req_t               alu_req;
	logic [SUM_W:0]         alu_y;
	logic                   borrow;

	// Configuration port: one register, always ready.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_WINDOW);
	assign prdata = (paddr[2] == ADDR_WINDOW) ? APB_DATA_W'(win_reg_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_reg_q <= WIN_RESET;
		end else if (cfg_wr) begin
			win_reg_q <= pwdata[WIN_W-1:0];
		end
	end

	// Window size clamped to 1..MAX_WINDOW.
	always_comb begin
		if (win_reg_q == '0) begin
			win_eff = EW_W'(1);
		end else if (int'(win_reg_q) > MAX_WINDOW) begin
			win_eff = EW_W'(MAX_WINDOW);
		end else begin
			win_eff = EW_W'(win_reg_q);
		end
	end

	// Handshakes.
	assign smp.ready     = (state_q == ST_IDLE);
	assign smp_take      = smp.valid && (state_q == ST_IDLE);
	assign res.valid     = res_valid_q;
	assign res.average   = res_avg_q;
	assign res.valid_res = res_ok_q;

	// Slot under the walk; a slot never written since the last clear reads as empty.
	assign entry   = used_q[idx_q[IDX_W-1:0]] ? store_q[idx_q[IDX_W-1:0]] : '0;
	assign pos_inc = EW_W'(pos_q) + EW_W'(1);
	assign rem_sh  = {rem_q, num_q[NUM_W-1]};

	// Shared unit: accumulate in the walk, trial subtract in the divide.
	always_comb begin
		if (state_q == ST_DIV) begin
			alu_req.op = ALU_SUB;
			alu_req.a  = SUM_W'(rem_sh);
			alu_req.b  = SUM_W'(win_eff);
		end else begin
			alu_req.op = ALU_ADD;
			alu_req.a  = sum_q;
			alu_req.b  = SUM_W'(entry);
		end
	end

	swa_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	assign borrow = alu_y[SUM_W];

	// Sample store data, written at the write position.
	always_ff @(posedge clk) begin
		if (smp_take && !smp.clear) begin
			store_q[pos_q] <= smp.sample;
		end
	end

	// Sequencer with its datapath and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			used_q      <= '0;
			idx_q       <= '0;
			sum_q       <= '0;
			rem_q       <= '0;
			num_q       <= '0;
			dcnt_q      <= '0;
			ok_q        <= 1'b0;
			res_valid_q <= 1'b0;
			res_avg_q   <= '0;
			res_ok_q    <= 1'b0;
		end else begin
			// The finishing state loads the result register itself.
			if (res_valid_q && res.ready && (state_q != ST_FIN)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (smp_take) begin
						idx_q <= '0;
						sum_q <= '0;
						ok_q  <= 1'b0;
						if (smp.clear) begin
							used_q  <= '0;
							pos_q   <= '0;
							state_q <= ST_FIN;
						end else begin
							used_q[pos_q] <= 1'b1;
							pos_q   <= (pos_inc >= win_eff) ? '0 : pos_inc[IDX_W-1:0];
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					// One slot per cycle; an empty slot ends the walk with no valid mean.
					if (entry == '0) begin
						ok_q    <= 1'b0;
						state_q <= ST_FIN;
					end else begin
						sum_q <= alu_y[SUM_W-1:0];
						idx_q <= idx_q + EW_W'(1);
						if (idx_q == win_eff - EW_W'(1)) begin
							num_q   <= {alu_y[SUM_W-1:0], {FRAC_BITS{1'b0}}};
							rem_q   <= '0;
							dcnt_q  <= '0;
							ok_q    <= 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					// Restoring divide, one quotient bit per cycle into num_q.
					num_q <= {num_q[NUM_W-2:0], !borrow};
					rem_q <= borrow ? rem_sh[REM_W-1:0] : alu_y[REM_W-1:0];
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DCNT_W'(NUM_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Hand the result over once the output register is free.
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						res_ok_q    <= ok_q;
						res_avg_q   <= ok_q ? AVG_W'(num_q) : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// An invalid result always carries a zero average.
	`SWA_ASSERT_NEVER(a_invalid_zero, res_valid_q && !res_ok_q && (res_avg_q != '0), "invalid result with nonzero average")
	// A clear transaction leaves the write position at zero.
	`SWA_ASSERT_CLK(a_clear_pos, (smp_take && smp.clear) |=> (pos_q == '0), "clear did not reset position")
	// The walk stays inside the window.
	`SWA_ASSERT_CLK(a_walk_range, (state_q == ST_SUM) |-> (idx_q < win_eff), "walk index past window")
	// The divider remainder stays below the divisor.
	`SWA_ASSERT_CLK(a_rem_range, (state_q == ST_DIV) |-> (rem_q < win_eff), "remainder not below window")
	// A finished result waits while the previous one is still held.
	`SWA_ASSERT_CLK(a_fin_hold, ((state_q == ST_FIN) && res_valid_q && !res.ready) |=> (state_q == ST_FIN), "result overwritten")
endmodule
